[hdl/fpfa_pkg.sv]
package fpfa_pkg;

	localparam int MAX_PARTS = 16;
	localparam int IDX_W     = $clog2(MAX_PARTS);
	localparam int CNT_W     = $clog2(MAX_PARTS + 1);
	localparam int SIZE_W    = 20;
	localparam int BASE_W    = 24;
	localparam int OWNER_W   = 16;

	typedef enum logic [1:0] {
		OP_CLEAR  = 2'd0,
		OP_APPEND = 2'd1,
		OP_ALLOC  = 2'd2,
		OP_NONE   = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		STAT_DONE  = 2'd0,
		STAT_ALLOC = 2'd1,
		STAT_NOFIT = 2'd2,
		STAT_FULL  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		POL_FIRST = 2'd0,
		POL_BEST  = 2'd1,
		POL_WORST = 2'd2,
		POL_NONE  = 2'd3
	} policy_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_WRITE,
		S_EMIT
	} state_t;

endpackage

[hdl/fixed_partition_fit_allocator.sv]
// channel  direction  handshake                   payload
// in       to block   in_valid / in_stall         opcode, amount, process_id
// out      from block out_valid / out_stall       status, slot_index, slot_base, slot_size
// cfg      to block   cfg_wr_en (no wait)         cfg_wr_data = fit_policy
//
// clear, append and unknown opcodes write the pending result at accept, then wait in the emit state
// allocate scans one partition per cycle through the shared size compare unit, then
// passes a writeback state and a result state; first fit stops early
// the block takes one word at a time; in_stall is high from accept until the result
// has moved into the output register, which holds while out_stall is high
// arst_n clears the sequencer, part_count, next_base, fit_policy and out_valid;
// the partition store itself is not cleared, only entries below part_count are read
module fixed_partition_fit_allocator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  opcode,
	input  logic [19:0] amount,
	input  logic [15:0] process_id,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [3:0]  slot_index,
	output logic [23:0] slot_base,
	output logic [19:0] slot_size,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_wr_data
);

	// partition store, written at one address and read at the scan pointer only
	logic [fpfa_pkg::SIZE_W-1:0]  part_size_q  [fpfa_pkg::MAX_PARTS];
	logic [fpfa_pkg::BASE_W-1:0]  part_base_q  [fpfa_pkg::MAX_PARTS];
	logic                         part_free_q  [fpfa_pkg::MAX_PARTS];
	logic [fpfa_pkg::OWNER_W-1:0] part_owner_q [fpfa_pkg::MAX_PARTS];

	logic [fpfa_pkg::CNT_W-1:0]   part_count_q;
	logic [fpfa_pkg::BASE_W-1:0]  next_base_q;
	fpfa_pkg::policy_t            fit_policy_q;

	fpfa_pkg::state_t             state_q, state_d;

	// latched request
	logic [fpfa_pkg::SIZE_W-1:0]  req_q;
	logic [fpfa_pkg::OWNER_W-1:0] pid_q;

	// scan pointer and running winner
	logic [fpfa_pkg::IDX_W-1:0]   scan_idx_q;
	logic                         found_q;
	logic [fpfa_pkg::IDX_W-1:0]   win_idx_q;
	logic [fpfa_pkg::SIZE_W-1:0]  win_size_q;
	logic [fpfa_pkg::BASE_W-1:0]  win_base_q;

	// pending result, waiting for the output register
	fpfa_pkg::status_t            res_status_q;
	logic [fpfa_pkg::IDX_W-1:0]   res_index_q;
	logic [fpfa_pkg::BASE_W-1:0]  res_base_q;
	logic [fpfa_pkg::SIZE_W-1:0]  res_size_q;

	logic                         out_valid_q;
	fpfa_pkg::status_t            out_status_q;
	logic [fpfa_pkg::IDX_W-1:0]   out_index_q;
	logic [fpfa_pkg::BASE_W-1:0]  out_base_q;
	logic [fpfa_pkg::SIZE_W-1:0]  out_size_q;

	logic                         in_acc;
	logic                         out_load;
	logic                         scan_last;
	logic                         scan_stop;
	logic                         take;
	fpfa_pkg::opcode_t            op;

	// shared compare unit, fed from the scan pointer
	logic [fpfa_pkg::SIZE_W-1:0]  size_rd;
	logic [fpfa_pkg::BASE_W-1:0]  base_rd;
	logic                         free_rd;
	logic [fpfa_pkg::SIZE_W-1:0]  worst_ref;
	logic                         fits;
	logic                         smaller;
	logic                         larger;

	assign op      = fpfa_pkg::opcode_t'(opcode);
	assign size_rd = part_size_q[scan_idx_q];
	assign base_rd = part_base_q[scan_idx_q];
	assign free_rd = part_free_q[scan_idx_q];

	assign worst_ref = found_q ? win_size_q : '0;
	assign fits      = free_rd && (size_rd >= req_q);
	assign smaller   = size_rd < win_size_q;
	assign larger    = size_rd > worst_ref;

	// candidate decision for the current entry
	always_comb begin
		case (fit_policy_q)
			fpfa_pkg::POL_FIRST: take = fits;
			fpfa_pkg::POL_BEST:  take = fits && (!found_q || smaller);
			fpfa_pkg::POL_WORST: take = fits && larger;
			default:             take = 1'b0;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			fpfa_pkg::S_IDLE: begin
				if (in_valid) begin
					if (op == fpfa_pkg::OP_ALLOC && part_count_q != '0)
						state_d = fpfa_pkg::S_SCAN;
					else if (op == fpfa_pkg::OP_ALLOC)
						state_d = fpfa_pkg::S_WRITE;
					else
						state_d = fpfa_pkg::S_EMIT;
				end
			end
			fpfa_pkg::S_SCAN: begin
				if (scan_stop)
					state_d = fpfa_pkg::S_WRITE;
			end
			fpfa_pkg::S_WRITE: state_d = fpfa_pkg::S_EMIT;
			fpfa_pkg::S_EMIT: begin
				if (out_load)
					state_d = fpfa_pkg::S_IDLE;
			end
			default: state_d = fpfa_pkg::S_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_stall  = (state_q != fpfa_pkg::S_IDLE);
		in_acc    = in_valid && (state_q == fpfa_pkg::S_IDLE);
		scan_last = (({1'b0, scan_idx_q} + fpfa_pkg::CNT_W'(1)) == part_count_q);
		// first fit ends the scan on its first hit
		scan_stop = scan_last || (take && fit_policy_q == fpfa_pkg::POL_FIRST);
		out_load  = (state_q == fpfa_pkg::S_EMIT) && (!out_valid_q || !out_stall);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= fpfa_pkg::S_IDLE;
			part_count_q <= '0;
			next_base_q  <= '0;
			fit_policy_q <= fpfa_pkg::POL_FIRST;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en)
				fit_policy_q <= fpfa_pkg::policy_t'(cfg_wr_data);
			if (in_acc) begin
				case (op)
					fpfa_pkg::OP_CLEAR: begin
						part_count_q <= '0;
						next_base_q  <= '0;
					end
					fpfa_pkg::OP_APPEND: begin
						if (part_count_q != fpfa_pkg::CNT_W'(fpfa_pkg::MAX_PARTS)) begin
							part_count_q <= part_count_q + fpfa_pkg::CNT_W'(1);
							// base wraps at the address width
							next_base_q  <= next_base_q + fpfa_pkg::BASE_W'(amount);
						end
					end
					default: ;
				endcase
			end
			if (out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	// datapath, no reset needed
	always_ff @(posedge clk) begin
		if (in_acc) begin
			req_q      <= amount;
			pid_q      <= process_id;
			scan_idx_q <= '0;
			found_q    <= 1'b0;
			win_idx_q  <= '0;
			win_size_q <= '0;
			win_base_q <= '0;
			if (op == fpfa_pkg::OP_APPEND
					&& part_count_q != fpfa_pkg::CNT_W'(fpfa_pkg::MAX_PARTS)) begin
				part_size_q[part_count_q[fpfa_pkg::IDX_W-1:0]]  <= amount;
				part_base_q[part_count_q[fpfa_pkg::IDX_W-1:0]]  <= next_base_q;
				part_free_q[part_count_q[fpfa_pkg::IDX_W-1:0]]  <= 1'b1;
				part_owner_q[part_count_q[fpfa_pkg::IDX_W-1:0]] <= '0;
				res_status_q <= fpfa_pkg::STAT_DONE;
				res_index_q  <= part_count_q[fpfa_pkg::IDX_W-1:0];
				res_base_q   <= next_base_q;
				res_size_q   <= amount;
			end else begin
				// append on a full table, or a word with no partition to report
				if (op == fpfa_pkg::OP_APPEND)
					res_status_q <= fpfa_pkg::STAT_FULL;
				else
					res_status_q <= fpfa_pkg::STAT_DONE;
				res_index_q <= '0;
				res_base_q  <= '0;
				res_size_q  <= '0;
			end
		end
		if (state_q == fpfa_pkg::S_SCAN) begin
			scan_idx_q <= scan_idx_q + fpfa_pkg::IDX_W'(1);
			if (take) begin
				found_q    <= 1'b1;
				win_idx_q  <= scan_idx_q;
				win_size_q <= size_rd;
				win_base_q <= base_rd;
			end
		end
		if (state_q == fpfa_pkg::S_WRITE) begin
			if (found_q) begin
				part_free_q[win_idx_q]  <= 1'b0;
				part_owner_q[win_idx_q] <= pid_q;
				res_status_q <= fpfa_pkg::STAT_ALLOC;
				res_index_q  <= win_idx_q;
				res_base_q   <= win_base_q;
				res_size_q   <= win_size_q;
			end else begin
				res_status_q <= fpfa_pkg::STAT_NOFIT;
			end
		end
		if (out_load) begin
			out_status_q <= res_status_q;
			out_index_q  <= res_index_q;
			out_base_q   <= res_base_q;
			out_size_q   <= res_size_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = out_status_q;
	assign slot_index = out_index_q;
	assign slot_base  = out_base_q;
	assign slot_size  = out_size_q;

endmodule

[hdl/fpfa_checker.sv]
module fpfa_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [1:0]  status,
	input logic [3:0]  slot_index,
	input logic [23:0] slot_base,
	input logic [19:0] slot_size
);

	// an accepted word keeps the input side busy in the cycle after
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input accepted on back-to-back cycles");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(slot_index)
			&& $stable(slot_base) && $stable(slot_size))
		else $error("stalled result changed");

	// failing results carry no partition
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == fpfa_pkg::STAT_NOFIT || status == fpfa_pkg::STAT_FULL)
			|-> slot_index == '0 && slot_base == '0 && slot_size == '0)
		else $error("failing result carries partition fields");

	// no result word shows up while nothing is in flight
	a_no_result_while_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid && !in_stall |=> !out_valid)
		else $error("result appeared with no word in flight");

endmodule

bind fixed_partition_fit_allocator fpfa_checker u_fpfa_checker (.*);

[sim/fixed_partition_fit_allocator_checker.sv]
`timescale 1ns / 1ps
module fixed_partition_fit_allocator_checker
	import fpfa_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_stall,
	input  logic [1:0]        opcode,
	input  logic [SIZE_W-1:0] amount,
	input  logic [15:0]       process_id,
	input  logic              out_valid,
	input  logic              out_stall,
	input  logic [1:0]        status,
	input  logic [3:0]        slot_index,
	input  logic [23:0]       slot_base,
	input  logic [SIZE_W-1:0] slot_size,
	input  logic              cfg_wr_en,
	input  logic [1:0]        cfg_wr_data,
	output int                open_replies,
	output int                mismatches
);

	typedef struct packed {
		status_t           status;
		logic [IDX_W-1:0]  index;
		logic [BASE_W-1:0] base;
		logic [SIZE_W-1:0] size;
	} reply_t;

	logic [SIZE_W-1:0]  tbl_size  [MAX_PARTS];
	logic [BASE_W-1:0]  tbl_base  [MAX_PARTS];
	logic               tbl_free  [MAX_PARTS];
	logic [OWNER_W-1:0] tbl_owner [MAX_PARTS];
	logic [CNT_W-1:0]   used_slots;
	logic [BASE_W-1:0]  next_base;
	policy_t            policy;
	reply_t             reply_q [$];

	// one request against the partition table, returns the reply word it causes
	function automatic reply_t serve_request(opcode_t op, logic [SIZE_W-1:0] amt,
			logic [OWNER_W-1:0] pid);
		reply_t r;
		logic   found;
		int     win;
		int     k;
		r = '0;
		r.status = STAT_DONE;
		found = 1'b0;
		win = 0;
		k = used_slots;
		case (op)
			OP_CLEAR: begin
				used_slots = '0;
				next_base = '0;
			end
			OP_APPEND: begin
				if (k >= MAX_PARTS) begin
					r.status = STAT_FULL;
				end else begin
					tbl_size[k] = amt;
					tbl_base[k] = next_base;
					tbl_free[k] = 1'b1;
					tbl_owner[k] = '0;
					next_base = next_base + BASE_W'(amt);
					used_slots = used_slots + 1'b1;
					r.index = k[IDX_W-1:0];
					r.base = tbl_base[k];
					r.size = amt;
				end
			end
			OP_ALLOC: begin
				for (int i = 0; i < MAX_PARTS; i++) begin
					if (i < k && tbl_free[i] && tbl_size[i] >= amt) begin
						case (policy)
							POL_FIRST: if (!found) begin
								found = 1'b1;
								win = i;
							end
							POL_BEST: if (!found || tbl_size[i] < tbl_size[win]) begin
								found = 1'b1;
								win = i;
							end
							// an empty partition never wins here
							POL_WORST: if (tbl_size[i] > (found ? tbl_size[win] : '0)) begin
								found = 1'b1;
								win = i;
							end
							default: ;
						endcase
					end
				end
				if (found) begin
					tbl_free[win] = 1'b0;
					tbl_owner[win] = pid;
					r.status = STAT_ALLOC;
					r.index = win[IDX_W-1:0];
					r.base = tbl_base[win];
					r.size = tbl_size[win];
				end else begin
					r.status = STAT_NOFIT;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic check_field(input string name, input logic [BASE_W-1:0] want,
			input logic [BASE_W-1:0] got);
		if (got !== want) begin
			$error("%s expected %0d actual %0d", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		reply_t want;
		if (!arst_n) begin
			used_slots = '0;
			next_base = '0;
			policy = POL_FIRST;
			reply_q.delete();
			open_replies = 0;
			mismatches = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (reply_q.size() == 0) begin
					$error("result word with none pending: status %0d index %0d", status,
						slot_index);
					mismatches++;
				end else begin
					want = reply_q.pop_front();
					check_field("status", BASE_W'(want.status), BASE_W'(status));
					check_field("slot_index", BASE_W'(want.index), BASE_W'(slot_index));
					check_field("slot_base", want.base, slot_base);
					check_field("slot_size", BASE_W'(want.size), BASE_W'(slot_size));
				end
			end
			if (in_valid && !in_stall)
				reply_q.push_back(serve_request(opcode_t'(opcode), amount, process_id));
			if (cfg_wr_en)
				policy = policy_t'(cfg_wr_data);
			open_replies = reply_q.size();
		end
	end

endmodule

[sim/tb_fixed_partition_fit_allocator.sv]
`timescale 1ns / 1ps
module tb_fixed_partition_fit_allocator;
	import fpfa_pkg::*;

	localparam int HALF_PERIOD     = 6;
	localparam int RESET_CYCLES    = 7;
	// bound for the whole run, random gaps and stalls included
	localparam int CYCLE_LIMIT     = 400000;
	// longest allocate scan plus writeback and result, with margin
	localparam int DRAIN_CYCLES    = 40;
	localparam int WORDS_PER_ROUND = 43;
	localparam int ROUNDS_PER_MODE = 5;

	logic              clk         = 1'b0;
	logic              arst_n      = 1'b0;
	logic              in_valid    = 1'b0;
	logic              in_stall;
	logic [1:0]        opcode      = OP_NONE;
	logic [SIZE_W-1:0] amount      = '0;
	logic [15:0]       process_id  = '0;
	logic              out_valid;
	logic              out_stall   = 1'b0;
	logic [1:0]        status;
	logic [3:0]        slot_index;
	logic [23:0]       slot_base;
	logic [SIZE_W-1:0] slot_size;
	logic              cfg_wr_en   = 1'b0;
	logic [1:0]        cfg_wr_data = POL_FIRST;

	int send_idle_pct = 0;
	int stall_pct     = 0;
	int words_sent    = 0;
	int cycles        = 0;
	int open_replies;
	int mismatches;

	// partition sizes that fill the table in the directed part: both size
	// extremes, empty partitions and ties for best and worst fit
	logic [SIZE_W-1:0] fill_sizes [MAX_PARTS] = '{
		20'd0, 20'hFFFFF, 20'd8, 20'd3, 20'd8, 20'd0, 20'd5, 20'd1,
		20'd2, 20'd3, 20'd4, 20'd5, 20'd6, 20'd7, 20'd0, 20'd9
	};

	fixed_partition_fit_allocator u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.opcode      (opcode),
		.amount      (amount),
		.process_id  (process_id),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.slot_index  (slot_index),
		.slot_base   (slot_base),
		.slot_size   (slot_size),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	fixed_partition_fit_allocator_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.opcode       (opcode),
		.amount       (amount),
		.process_id   (process_id),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.slot_index   (slot_index),
		.slot_base    (slot_base),
		.slot_size    (slot_size),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.open_replies (open_replies),
		.mismatches   (mismatches)
	);

	always #HALF_PERIOD clk = ~clk;

	// receiver back-pressure, redrawn every cycle at the falling edge
	always @(negedge clk)
		out_stall <= ($urandom_range(99) < stall_pct);

	// hard stop in case the block hangs
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL fixed_partition_fit_allocator");
			$finish;
		end
	end

	// present one word at the falling edge, maybe after a random gap,
	// and hold it until the block takes it at a rising edge
	task automatic send_word(input opcode_t op, input logic [SIZE_W-1:0] amt,
			input logic [15:0] pid);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		opcode = op;
		amount = amt;
		process_id = pid;
		do @(posedge clk); while (in_stall);
		if (op != OP_NONE)
			words_sent++;
	endtask

	// policy changes only with the block idle: stop sending, let every
	// pending word come back and the sequencer settle, then write
	task automatic set_policy(input policy_t p);
		@(negedge clk);
		in_valid = 1'b0;
		while (open_replies != 0) @(negedge clk);
		repeat (3) @(negedge clk);
		cfg_wr_en = 1'b1;
		cfg_wr_data = p;
		@(negedge clk);
		cfg_wr_en = 1'b0;
	endtask

	// mostly small sizes so that requests fit and ties are common
	function automatic logic [SIZE_W-1:0] pick_size();
		int roll;
		roll = $urandom_range(99);
		if (roll < 70)
			return SIZE_W'($urandom_range(15));
		if (roll < 85)
			return SIZE_W'($urandom_range(1023));
		if (roll < 95)
			return SIZE_W'($urandom);
		return '1;
	endfunction

	// one burst: usually clear, a run of appends (often past a full table),
	// then some allocates; now and then just noise with any opcode
	task automatic run_burst();
		int appends;
		int allocs;
		appends = $urandom_range(1, 18);
		allocs = $urandom_range(1, 6);
		if ($urandom_range(9) == 0) begin
			repeat ($urandom_range(1, 4))
				send_word(opcode_t'($urandom_range(3)), SIZE_W'($urandom), 16'($urandom));
			return;
		end
		// sometimes keep the old table so appends land on a partly used one
		if ($urandom_range(3) != 0)
			send_word(OP_CLEAR, SIZE_W'($urandom), 16'($urandom));
		repeat (appends)
			send_word(OP_APPEND, pick_size(), 16'($urandom));
		repeat (allocs)
			send_word(OP_ALLOC, pick_size(), 16'($urandom));
	endtask

	initial begin
		int target;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;

		// directed part, no idling
		set_policy(POL_FIRST);
		send_word(OP_CLEAR, '1, '1);
		// allocate on an empty table finds nothing
		send_word(OP_ALLOC, 20'd5, 16'd1);
		// unknown opcode with every payload bit set
		send_word(OP_NONE, '1, '1);
		foreach (fill_sizes[i])
			send_word(OP_APPEND, fill_sizes[i], '1);
		// one append too many
		send_word(OP_APPEND, 20'd1, '0);
		send_word(OP_ALLOC, '0, '0);
		send_word(OP_ALLOC, '1, '1);
		// best fit picks the lower of two equal sizes
		set_policy(POL_BEST);
		send_word(OP_ALLOC, 20'd3, 16'h1234);
		set_policy(POL_WORST);
		send_word(OP_ALLOC, '0, 16'h00FF);
		// unused policy code selects nothing
		set_policy(POL_NONE);
		send_word(OP_ALLOC, '0, 16'h0F0F);

		// random part in three idling modes, each in rounds with a fresh policy
		for (int mode = 0; mode < 3; mode++) begin
			case (mode)
				0: begin
					send_idle_pct = 26;
					stall_pct = 79;
				end
				1: begin
					send_idle_pct = 79;
					stall_pct = 26;
				end
				default: begin
					send_idle_pct = 0;
					stall_pct = 0;
				end
			endcase
			for (int r = 0; r < ROUNDS_PER_MODE; r++) begin
				if (r < 4)
					set_policy(policy_t'(r));
				else
					set_policy(policy_t'($urandom_range(3)));
				target = words_sent + WORDS_PER_ROUND;
				while (words_sent < target)
					run_burst();
			end
		end

		// drain, then watch a while longer for stray result words
		@(negedge clk);
		in_valid = 1'b0;
		send_idle_pct = 0;
		stall_pct = 0;
		while (open_replies != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatches == 0)
			$display("PASS fixed_partition_fit_allocator");
		else
			$display("FAIL fixed_partition_fit_allocator");
		$finish;
	end

endmodule

[files.f]
hdl/fpfa_pkg.sv
hdl/fixed_partition_fit_allocator.sv
hdl/fpfa_checker.sv
sim/fixed_partition_fit_allocator_checker.sv
sim/tb_fixed_partition_fit_allocator.sv
